[hw/rtl/ejes_pkg.sv]
// Package: widths, event codes, register indexes and the quadrature step table.
package ejes_pkg;

	localparam int ADC_BITS   = 10;
	localparam int THR_BITS   = 10;
	localparam int CMP_BITS   = (ADC_BITS > THR_BITS) ? ADC_BITS : THR_BITS;
	localparam int DET_BITS   = 3;
	localparam int STEP_BITS  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = (THR_BITS > DET_BITS) ? THR_BITS : DET_BITS;

	// Input word: six single-bit fields, then joy_x, then joy_y.
	localparam int IN_BITS    = 6 + 2 * ADC_BITS;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int EV_BITS    = 4;
	localparam int OUT_TDATA_W = ((EV_BITS + 7) / 8) * 8;

	localparam logic [THR_BITS-1:0]  LOW_THR_RST  = THR_BITS'(100);
	localparam logic [THR_BITS-1:0]  HIGH_THR_RST = THR_BITS'(900);
	localparam logic [DET_BITS-1:0]  DET_MIN_RST  = DET_BITS'(2);
	localparam logic [1:0]           PINS_DETENT  = 2'b11;
	localparam logic signed [STEP_BITS-1:0] STEP_MAX = STEP_BITS'(4);
	localparam logic signed [STEP_BITS-1:0] STEP_MIN = -STEP_BITS'(4);

	typedef enum logic [EV_BITS-1:0] {
		EV_NONE      = 4'd0,
		EV_ENC_CCW   = 4'd1,
		EV_ENC_CW    = 4'd2,
		EV_ENC_PRESS = 4'd3,
		EV_JOY_PRESS = 4'd4,
		EV_RIGHT     = 4'd5,
		EV_LEFT      = 4'd6,
		EV_DOWN      = 4'd7,
		EV_UP        = 4'd8
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOW_THR  = 2'd0,
		CFG_HIGH_THR = 2'd1,
		CFG_DET_MIN  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [ADC_BITS-1:0] joy_y;
		logic [ADC_BITS-1:0] joy_x;
		logic                joy_button_settled;
		logic                joy_button_first;
		logic                enc_button_settled;
		logic                enc_button_first;
		logic                enc_b;
		logic                enc_a;
	} scan_t;

	// Step for a move from pin state idx[3:2] to pin state idx[1:0].
	function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
		logic signed [1:0] s;
		case (idx)
			4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
			4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
			default: s = 2'sd0;
		endcase
		return s;
	endfunction

endpackage

[hw/rtl/encoder_joystick_event_scanner_top.sv]
// Top level: scan sample decoder for a rotary encoder, two buttons and a joystick.
//
// Usage:
//   s_axis carries one scan sample per word; tdata holds, from bit 0 up:
//   enc_a, enc_b, enc_button_first, enc_button_settled, joy_button_first,
//   joy_button_settled, joy_x, joy_y, then zero fill.
//   m_axis returns exactly one event word per sample; tdata[3:0] is
//   event_code (0 none, 1 ccw, 2 cw, 3 encoder press, 4 joystick press,
//   5 right, 6 left, 7 down, 8 up).
//   cfg writes a register by index (0 low threshold, 1 high threshold,
//   2 detent minimum); cfg_ready is always high. Write only while idle.
// Registers: the accept edge loads the input register; the decoded event
//   is loaded into the output register as the word leaves the input stage,
//   which waits while the output word is stalled.
// Throughput: one word per cycle while m_axis_tready is high; the encoder
//   state update and the event priority chain sit between the input and output registers.
// Reset: thresholds go to 100 and 900, detent minimum to 2, last pin state
//   to both-high, step count to zero, both stages empty.
// Stall: while m_axis_tready is low the output word holds, the input stage
//   fills and s_axis_tready drops once both stages are occupied.
module encoder_joystick_event_scanner_top
	import ejes_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// enc_a, enc_b, enc_button_first, enc_button_settled, joy_button_first,
	// joy_button_settled, joy_x, joy_y, zero fill
	input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// event_code, zero fill
	output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	logic                        valid_s1;
	scan_t                       scan_s1;
	logic                        valid_s2;
	event_t                      code_s2;

	logic [THR_BITS-1:0]         low_thr_q;
	logic [THR_BITS-1:0]         high_thr_q;
	logic [DET_BITS-1:0]         det_min_q;
	logic [1:0]                  last_pins_q;
	logic signed [STEP_BITS-1:0] step_q;

	logic                        adv_s2;
	logic                        adv_s1;
	logic [1:0]                  pins;
	logic                        pins_moved;
	logic signed [STEP_BITS:0]   step_sum;
	logic signed [STEP_BITS-1:0] step_sat;
	logic signed [STEP_BITS-1:0] step_next;
	logic [DET_BITS-1:0]         need;
	logic signed [DET_BITS+1:0]  cap_x;
	logic signed [DET_BITS+1:0]  need_x;
	logic                        at_detent;
	logic [CMP_BITS-1:0]         x_c, y_c, low_c, high_c;
	event_t                      ev;

	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && adv_s2;
	assign s_axis_tready = !valid_s1 || adv_s2;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = OUT_TDATA_W'(code_s2);

	assign pins       = {scan_s1.enc_b, scan_s1.enc_a};
	assign pins_moved = (pins != last_pins_q);
	assign step_sum   = (STEP_BITS+1)'(step_q) + (STEP_BITS+1)'(quad_step({last_pins_q, pins}));
	assign need       = (det_min_q == '0) ? DET_BITS'(1) : det_min_q;
	assign at_detent  = pins_moved && (pins == PINS_DETENT);
	assign x_c        = CMP_BITS'(scan_s1.joy_x);
	assign y_c        = CMP_BITS'(scan_s1.joy_y);
	assign low_c      = CMP_BITS'(low_thr_q);
	assign high_c     = CMP_BITS'(high_thr_q);

	always_comb begin
		// clamp: the sum moves by at most one past the limit
		if (step_sum > (STEP_BITS+1)'(STEP_MAX)) begin
			step_sat = STEP_MAX;
		end else if (step_sum < (STEP_BITS+1)'(STEP_MIN)) begin
			step_sat = STEP_MIN;
		end else begin
			step_sat = step_sum[STEP_BITS-1:0];
		end

		if (!pins_moved) begin
			step_next = step_q;
		end else if (at_detent) begin
			step_next = '0;
		end else begin
			step_next = step_sat;
		end

		cap_x  = (DET_BITS+2)'(step_sat);
		need_x = (DET_BITS+2)'({2'b00, need});

		if (at_detent && cap_x >= need_x) begin
			ev = EV_ENC_CCW;
		end else if (at_detent && cap_x <= -need_x) begin
			ev = EV_ENC_CW;
		end else if (!scan_s1.enc_button_first && !scan_s1.enc_button_settled) begin
			ev = EV_ENC_PRESS;
		end else if (!scan_s1.joy_button_first && !scan_s1.joy_button_settled) begin
			ev = EV_JOY_PRESS;
		end else if (x_c < low_c) begin
			ev = EV_RIGHT;
		end else if (x_c > high_c) begin
			ev = EV_LEFT;
		end else if (y_c < low_c) begin
			ev = EV_DOWN;
		end else if (y_c > high_c) begin
			ev = EV_UP;
		end else begin
			ev = EV_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thr_q  <= LOW_THR_RST;
			high_thr_q <= HIGH_THR_RST;
			det_min_q  <= DET_MIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LOW_THR:  low_thr_q  <= cfg_data[THR_BITS-1:0];
				CFG_HIGH_THR: high_thr_q <= cfg_data[THR_BITS-1:0];
				CFG_DET_MIN:  det_min_q  <= cfg_data[DET_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			last_pins_q <= PINS_DETENT;
			step_q      <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			// advance encoder state only as a word leaves the input stage
			if (adv_s1) begin
				last_pins_q <= pins;
				step_q      <= step_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			scan_s1 <= scan_t'(s_axis_tdata[IN_BITS-1:0]);
		end
		if (adv_s1) begin
			code_s2 <= ev;
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_MAX && step_q >= STEP_MIN)
		else $error("step count out of range");

	a_detent_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && at_detent |=> step_q == '0)
		else $error("step count not cleared at detent");

	a_rot_at_detent: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && (ev == EV_ENC_CCW || ev == EV_ENC_CW) |-> pins == PINS_DETENT && pins_moved)
		else $error("rotation reported away from detent");

	a_pins_track: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> last_pins_q == $past(pins))
		else $error("last pin state not tracked");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_axis_tready |=> valid_s2 && $stable(code_s2))
		else $error("output word lost while stalled");

endmodule
